>>> rtl/core/assert_macros.svh
// Shared assertion shorthands.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is held.
`define SLAB_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, muted while reset is held.
`define SLAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/slab_pkg.sv
package slab_pkg;

    localparam int unsigned Q     = 30;
    localparam int unsigned LIN_W = 31;

    typedef logic [LIN_W-1:0] t_lin;
    typedef t_lin             t_lin_tab [256];
    typedef logic [29:0]      t_coef;
    typedef t_coef            t_coef_tab [9];

    typedef struct packed {
        t_lin lin_r;
        t_lin lin_g;
        t_lin lin_b;
        logic frame_end;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam int unsigned QDEPTH = 4;

    // X / 0.950456 and Z / 1.088754, rounded, as multiply by reciprocal plus correction
    localparam logic [16:0] XN_MUL = 17'd125000;
    localparam logic [15:0] XN_ADD = 16'd59403;
    localparam logic [16:0] XN_DIV = 17'd118807;
    localparam logic [31:0] XN_RCP = 32'((64'd125000 << 31) / 64'd118807);
    localparam logic [18:0] ZN_MUL = 19'd500000;
    localparam logic [18:0] ZN_ADD = 19'd272188;
    localparam logic [19:0] ZN_DIV = 20'd544377;
    localparam logic [31:0] ZN_RCP = 32'((64'd500000 << 31) / 64'd544377);

    // f(t) linear segment: (9033 t + 160 + 580) / 1160, valid for t <= epsilon
    localparam logic [23:0] F_THR = 24'd9509057;
    localparam logic [13:0] F_MUL = 14'd9033;
    localparam logic [37:0] F_ADD = 38'd171798692420;
    localparam logic [10:0] F_DIV = 11'd1160;
    localparam logic [28:0] F_RCP = 29'((64'd1 << 36) / 64'd145);
    localparam int unsigned F_LAT = 2 * LIN_W + 1;

    localparam int unsigned XYZ_E7 [9] = '{
        4124564, 3575761, 1804375,
        2126729, 7151522,  721750,
         193339, 1191920, 9503041
    };

    function automatic longint unsigned root5_q(input longint unsigned s);
        longint unsigned y;
        longint unsigned c;
        longint unsigned c2;
        longint unsigned c4;
        y = 64'd0;
        for (int k = 30; k >= 0; k--) begin
            c = y + (64'd1 << k);
            if (c <= (64'd1 << 30)) begin
                c2 = (c * c) >> 30;
                c4 = (c2 * c2) >> 30;
                if (((c4 * c) >> 30) <= s) begin
                    y = c;
                end
            end
        end
        return y;
    endfunction

    function automatic t_lin expand_q(input longint unsigned v);
        longint unsigned num;
        longint unsigned x;
        longint unsigned s;
        longint unsigned r;
        if (v <= 64'd10) begin
            num = (v * 64'd100) << 30;
            r = num / 64'd329460 + (((num % 64'd329460) * 64'd2 >= 64'd329460) ? 64'd1 : 64'd0);
        end else begin
            x = (((64'd1000 * v + 64'd14025) << 30) + 64'd134512) / 64'd269025;
            s = (x * x + (64'd1 << 29)) >> 30;
            r = (s * root5_q(s) + (64'd1 << 29)) >> 30;
        end
        return t_lin'(r);
    endfunction

    function automatic t_lin_tab build_lin_tab();
        t_lin_tab t;
        for (int v = 0; v < 256; v++) begin
            t[v] = expand_q(64'(v));
        end
        return t;
    endfunction

    function automatic t_coef_tab build_coef();
        t_coef_tab t;
        for (int k = 0; k < 9; k++) begin
            t[k] = t_coef'(((64'(XYZ_E7[k]) << 30) + 64'd5000000) / 64'd10000000);
        end
        return t;
    endfunction

    localparam t_lin_tab  LIN_TAB = build_lin_tab();
    localparam t_coef_tab COEF    = build_coef();

endpackage

>>> rtl/core/slab_pix_if.sv
interface slab_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;

    modport source (output valid, red, green, blue, frame_end, input ready);
    modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

>>> rtl/core/slab_lab_if.sv
interface slab_lab_if;
    logic               valid;
    logic               ready;
    logic        [10:0] lightness;
    logic signed [11:0] green_red_axis;
    logic signed [11:0] blue_yellow_axis;
    logic               frame_end_out;

    modport source (output valid, lightness, green_red_axis, blue_yellow_axis, frame_end_out,
                    input ready);
    modport sink   (input valid, lightness, green_red_axis, blue_yellow_axis, frame_end_out,
                    output ready);
endinterface

>>> rtl/core/slab_front.sv
`include "assert_macros.svh"

module slab_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    slab_pix_if.sink          i_pix,
    input  slab_pkg::t_q_stat i_qs,
    output logic              o_push,
    output slab_pkg::t_item   o_item
);

    logic            r_valid;
    logic            n_valid;
    slab_pkg::t_item r_item;
    logic            accept;

    assign o_push      = r_valid && !i_qs.full;
    assign i_pix.ready = !r_valid || o_push;
    assign accept      = i_pix.valid && i_pix.ready;
    assign o_item      = r_item;

    always_comb begin
        priority if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // gamma expansion by table, one lookup per channel
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.lin_r     <= slab_pkg::LIN_TAB[i_pix.red];
            r_item.lin_g     <= slab_pkg::LIN_TAB[i_pix.green];
            r_item.lin_b     <= slab_pkg::LIN_TAB[i_pix.blue];
            r_item.frame_end <= i_pix.frame_end;
        end
    end

    `SLAB_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, accept, r_valid)

endmodule

>>> rtl/core/slab_queue.sv
`include "assert_macros.svh"

module slab_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  slab_pkg::t_item   i_item,
    input  logic              i_pop,
    output slab_pkg::t_item   o_item,
    output slab_pkg::t_q_stat o_qs
);

    localparam int unsigned DEPTH = slab_pkg::QDEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);

    slab_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [PW:0]     r_count;

    assign o_qs.full  = (r_count == (PW+1)'(DEPTH));
    assign o_qs.empty = (r_count == '0);
    assign o_item     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `SLAB_ASSERT(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= (PW+1)'(DEPTH))
    `SLAB_ASSERT(a_q_no_overrun, i_clk, i_rst_n, i_push && o_qs.full, i_pop)

endmodule

>>> rtl/core/slab_labf.sv
module slab_labf (
    input  logic           i_clk,
    input  logic           i_en,
    input  slab_pkg::t_lin i_t,
    output slab_pkg::t_lin o_f
);

    localparam int unsigned N = slab_pkg::LIN_W;

    // cube root, one bit per step, square then cube in separate stages
    slab_pkg::t_lin r_ay  [N];
    slab_pkg::t_lin r_as  [N];
    logic [31:0]    r_asq [N];
    slab_pkg::t_lin r_by  [N];
    slab_pkg::t_lin r_bs  [N];

    slab_pkg::t_lin y_in [N];
    slab_pkg::t_lin s_in [N];
    slab_pkg::t_lin c_a  [N];
    slab_pkg::t_lin c_b  [N];
    logic [61:0]    p_sq [N];
    logic [62:0]    p_cu [N];

    // linear segment, tapped from the root pipeline four stages before its end
    logic [38:0]    r_ln1;
    logic [38:0]    r_ln2;
    logic [38:0]    r_ln3;
    logic [60:0]    r_lp;
    logic [28:0]    r_lq;
    logic [39:0]    r_lm;
    slab_pkg::t_lin r_lf;
    slab_pkg::t_lin r_f;
    logic [39:0]    ldiff;
    logic [11:0]    lrem;
    logic [1:0]     ladj;

    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                y_in[k] = '0;
                s_in[k] = i_t;
            end else begin
                y_in[k] = r_by[k-1];
                s_in[k] = r_bs[k-1];
            end
            c_a[k]  = y_in[k] | (slab_pkg::t_lin'(1) << (N - 1 - k));
            p_sq[k] = 62'(c_a[k]) * 62'(c_a[k]);
            c_b[k]  = r_ay[k] | (slab_pkg::t_lin'(1) << (N - 1 - k));
            p_cu[k] = 63'(r_asq[k]) * 63'(c_b[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_asq[k] <= p_sq[k][61:30];
                r_ay[k]  <= y_in[k];
                r_as[k]  <= s_in[k];
                r_by[k]  <= (p_cu[k][62:30] <= 33'(r_as[k])) ? c_b[k] : r_ay[k];
                r_bs[k]  <= r_as[k];
            end
        end
    end

    assign ldiff = 40'(r_ln3) - r_lm;
    assign lrem  = ldiff[11:0];

    always_comb begin
        priority if (lrem >= 12'(slab_pkg::F_DIV) * 12'd2) begin
            ladj = 2'd2;
        end else if (lrem >= 12'(slab_pkg::F_DIV)) begin
            ladj = 2'd1;
        end else begin
            ladj = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ln1 <= 39'(slab_pkg::F_MUL) * 39'(r_bs[N-3][23:0]) + 39'(slab_pkg::F_ADD);
            r_ln2 <= r_ln1;
            r_lp  <= 61'(r_ln1[38:7]) * 61'(slab_pkg::F_RCP);
            r_ln3 <= r_ln2;
            r_lq  <= r_lp[60:32];
            r_lm  <= 40'(r_lp[60:32]) * 40'(slab_pkg::F_DIV);
            r_lf  <= slab_pkg::t_lin'(r_lq) + slab_pkg::t_lin'(ladj);
            r_f   <= (r_bs[N-1] > slab_pkg::t_lin'(slab_pkg::F_THR)) ? r_by[N-1] : r_lf;
        end
    end

    assign o_f = r_f;

endmodule

>>> rtl/core/slab_back.sv
`include "assert_macros.svh"

module slab_back #(
    parameter int unsigned FRAC_BITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slab_pkg::t_item   i_item,
    input  slab_pkg::t_q_stat i_qs,
    output logic              o_pop,
    slab_lab_if.source        o_lab
);

    localparam int unsigned D    = 5 + slab_pkg::F_LAT + 3;
    localparam int unsigned SH   = slab_pkg::Q - FRAC_BITS;
    localparam logic [41:0] HALF = 42'd1 << (SH - 1);
    localparam int unsigned LMAX = ((100 << FRAC_BITS) > 2047) ? 2047 : (100 << FRAC_BITS);

    logic         en;
    logic [D-1:0] r_v;
    logic [D-1:0] r_fe;

    slab_pkg::t_lin lin [3];
    logic [60:0]    r_p   [9];
    slab_pkg::t_lin r_xyz [3];
    logic [62:0]    sum   [3];

    logic [47:0] r_nx;
    logic [62:0] r_px;
    logic [49:0] r_nz;
    logic [62:0] r_pz;
    logic [47:0] r_nx4;
    logic [49:0] r_nz4;
    logic [31:0] r_qx;
    logic [31:0] r_qz;
    logic [48:0] r_mx;
    logic [51:0] r_mz;
    logic [48:0] dx;
    logic [51:0] dz;
    logic [20:0] remx;
    logic [20:0] remz;
    logic [1:0]  adjx;
    logic [1:0]  adjz;

    slab_pkg::t_lin r_y3;
    slab_pkg::t_lin r_y4;
    slab_pkg::t_lin r_xr;
    slab_pkg::t_lin r_yr;
    slab_pkg::t_lin r_zr;
    slab_pkg::t_lin fx;
    slab_pkg::t_lin fy;
    slab_pkg::t_lin fz;

    logic signed [41:0] sfx;
    logic signed [41:0] sfy;
    logic signed [41:0] sfz;
    logic signed [41:0] r_q   [3];
    logic               r_neg [3];
    logic [40:0]        r_mag [3];
    logic [41:0]        rm    [3];

    logic        [10:0] r_l;
    logic signed [11:0] r_a;
    logic signed [11:0] r_b;

    assign en    = !r_v[D-1] || o_lab.ready;
    assign o_pop = en && !i_qs.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[D-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fe <= {r_fe[D-2:0], i_item.frame_end};
        end
    end

    assign lin[0] = i_item.lin_r;
    assign lin[1] = i_item.lin_g;
    assign lin[2] = i_item.lin_b;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = 63'(r_p[3*i]) + 63'(r_p[3*i+1]) + 63'(r_p[3*i+2]) + (63'd1 << 29);
        end
    end

    // remainders are below three divisors, so two compares settle the quotient
    assign dx   = 49'(r_nx4) - r_mx;
    assign dz   = 52'(r_nz4) - r_mz;
    assign remx = dx[20:0];
    assign remz = dz[20:0];

    always_comb begin
        priority if (remx >= (21'(slab_pkg::XN_DIV) << 1)) begin
            adjx = 2'd2;
        end else if (remx >= 21'(slab_pkg::XN_DIV)) begin
            adjx = 2'd1;
        end else begin
            adjx = 2'd0;
        end
        priority if (remz >= (21'(slab_pkg::ZN_DIV) << 1)) begin
            adjz = 2'd2;
        end else if (remz >= 21'(slab_pkg::ZN_DIV)) begin
            adjz = 2'd1;
        end else begin
            adjz = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[3*i+j] <= 61'(slab_pkg::COEF[3*i+j]) * 61'(lin[j]);
                end
                r_xyz[i] <= sum[i][60:30];
            end
            r_nx  <= 48'(r_xyz[0]) * 48'(slab_pkg::XN_MUL) + 48'(slab_pkg::XN_ADD);
            r_px  <= 63'(r_xyz[0]) * 63'(slab_pkg::XN_RCP);
            r_nz  <= 50'(r_xyz[2]) * 50'(slab_pkg::ZN_MUL) + 50'(slab_pkg::ZN_ADD);
            r_pz  <= 63'(r_xyz[2]) * 63'(slab_pkg::ZN_RCP);
            r_y3  <= r_xyz[1];
            r_qx  <= r_px[62:31];
            r_mx  <= 49'(r_px[62:31]) * 49'(slab_pkg::XN_DIV);
            r_nx4 <= r_nx;
            r_qz  <= r_pz[62:31];
            r_mz  <= 52'(r_pz[62:31]) * 52'(slab_pkg::ZN_DIV);
            r_nz4 <= r_nz;
            r_y4  <= r_y3;
            r_xr  <= slab_pkg::t_lin'(r_qx + 32'(adjx));
            r_zr  <= slab_pkg::t_lin'(r_qz + 32'(adjz));
            r_yr  <= r_y4;
        end
    end

    slab_labf u_fx (.i_clk(i_clk), .i_en(en), .i_t(r_xr), .o_f(fx));
    slab_labf u_fy (.i_clk(i_clk), .i_en(en), .i_t(r_yr), .o_f(fy));
    slab_labf u_fz (.i_clk(i_clk), .i_en(en), .i_t(r_zr), .o_f(fz));

    assign sfx = signed'(42'(fx));
    assign sfy = signed'(42'(fy));
    assign sfz = signed'(42'(fz));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rm[k] = (42'(r_mag[k]) + HALF) >> SH;
        end
    end

    // rounding is on the magnitude: ties go away from zero
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q[0] <= sfy * 42'sd116 - (42'sd1 <<< 34);
            r_q[1] <= (sfx - sfy) * 42'sd500;
            r_q[2] <= (sfy - sfz) * 42'sd200;
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= r_q[k][41];
                r_mag[k] <= r_q[k][41] ? 41'(-r_q[k]) : 41'(r_q[k]);
            end
            if (r_neg[0]) begin
                r_l <= '0;
            end else if (rm[0] > 42'(LMAX)) begin
                r_l <= 11'(LMAX);
            end else begin
                r_l <= rm[0][10:0];
            end
            if (r_neg[1]) begin
                r_a <= (rm[1] > 42'd2048) ? 12'sh800 : signed'(-rm[1][11:0]);
            end else begin
                r_a <= (rm[1] > 42'd2047) ? 12'sh7FF : signed'(rm[1][11:0]);
            end
            if (r_neg[2]) begin
                r_b <= (rm[2] > 42'd2048) ? 12'sh800 : signed'(-rm[2][11:0]);
            end else begin
                r_b <= (rm[2] > 42'd2047) ? 12'sh7FF : signed'(rm[2][11:0]);
            end
        end
    end

    assign o_lab.valid            = r_v[D-1];
    assign o_lab.lightness        = r_l;
    assign o_lab.green_red_axis   = r_a;
    assign o_lab.blue_yellow_axis = r_b;
    assign o_lab.frame_end_out    = r_fe[D-1];

    `SLAB_ASSERT(a_pop_nonempty, i_clk, i_rst_n, o_pop, !i_qs.empty)

endmodule

>>> rtl/core/srgb_to_cielab_converter.sv
// Channel  Dir  Handshake    Payload
// i_pix    in   valid/ready  red, green, blue, frame_end
// o_lab    out  valid/ready  lightness, green_red_axis, blue_yellow_axis, frame_end_out
//
// Sustains one request per clock while o_lab is ready; most of the back pipeline is
// the 31-step cube root (two multiplies per step).
// Reset clears the valid flags and the queue pointers and count only.
// The back pipeline advances whenever its output register is empty or taken;
// the 4-entry queue lets the front keep taking requests while it is stalled.
module srgb_to_cielab_converter #(
    parameter int unsigned FRAC_BITS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slab_pix_if.sink   i_pix,
    slab_lab_if.source o_lab
);

    logic              push;
    logic              pop;
    slab_pkg::t_item   f_item;
    slab_pkg::t_item   q_item;
    slab_pkg::t_q_stat qs;

    slab_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_qs    (qs),
        .o_push  (push),
        .o_item  (f_item)
    );

    slab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_qs    (qs)
    );

    slab_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (q_item),
        .i_qs    (qs),
        .o_pop   (pop),
        .o_lab   (o_lab)
    );

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int unsigned FRAC_BITS = 4;
    localparam int unsigned QF        = 30;
    localparam longint unsigned ONE   = 64'd1 << QF;
    localparam int unsigned LATENCY   = 80;
    localparam int unsigned N_RANDOM  = 1000;

    typedef struct {
        logic        [10:0] lightness;
        logic signed [11:0] gr_axis;
        logic signed [11:0] by_axis;
        logic               fe;
    } lab_t;

    class lab_scoreboard;
        lab_t pending[$];
        int   mismatches;
        int   pixels;
        int   frames;
        longint unsigned mat_coef[9];

        function new();
            int unsigned e7[9] = '{4124564, 3575761, 1804375,
                                   2126729, 7151522, 721750,
                                   193339, 1191920, 9503041};
            for (int k = 0; k < 9; k++) begin
                mat_coef[k] = ((64'(e7[k]) << QF) + 64'd5000000) / 64'd10000000;
            end
            mismatches = 0;
            pixels = 0;
            frames = 0;
        endfunction

        // truncating Q30 product, as the root searches use
        function longint unsigned qmul(longint unsigned a, longint unsigned b);
            return (a * b) >> QF;
        endfunction

        function longint unsigned fifth_root(longint unsigned s);
            longint unsigned y;
            longint unsigned c;
            longint unsigned sq;
            y = 0;
            for (int k = QF; k >= 0; k--) begin
                c = y + (64'd1 << k);
                if (c <= ONE) begin
                    sq = qmul(c, c);
                    if (qmul(qmul(sq, sq), c) <= s) y = c;
                end
            end
            return y;
        endfunction

        function longint unsigned cube_root(longint unsigned s);
            longint unsigned y;
            longint unsigned c;
            y = 0;
            for (int k = QF; k >= 0; k--) begin
                c = y + (64'd1 << k);
                if (qmul(qmul(c, c), c) <= s) y = c;
            end
            return y;
        endfunction

        function longint unsigned linearise(longint unsigned v);
            longint unsigned num;
            longint unsigned x;
            longint unsigned s;
            if (v <= 10) begin
                num = (v * 100) << QF;
                return num / 329460 + (((num % 329460) * 2 >= 329460) ? 1 : 0);
            end
            x = (((1000 * v + 14025) << QF) + 134512) / 269025;
            s = (x * x + (ONE >> 1)) >> QF;
            return (s * fifth_root(s) + (ONE >> 1)) >> QF;
        endfunction

        function longint unsigned cie_f(longint unsigned t);
            if (t * 1000000 > (64'd8856 << QF)) return cube_root(t);
            return (9033 * t + 160 * ONE + 580) / 1160;
        endfunction

        function longint to_frac(longint v);
            longint unsigned half;
            half = 64'd1 << (QF - FRAC_BITS - 1);
            if (v >= 0) return longint'((unsigned'(v) + half) >> (QF - FRAC_BITS));
            return -longint'((unsigned'(-v) + half) >> (QF - FRAC_BITS));
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
            longint unsigned lin[3];
            longint unsigned xyz[3];
            longint unsigned acc;
            longint unsigned fx, fy, fz;
            longint lv, av, bv, lmax;
            lab_t e;
            lin[0] = linearise(r);
            lin[1] = linearise(g);
            lin[2] = linearise(b);
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) acc += mat_coef[i*3+j] * lin[j];
                xyz[i] = (acc + (ONE >> 1)) >> QF;
            end
            fx = cie_f((xyz[0] * 1000000 + 475228) / 950456);
            fy = cie_f(xyz[1]);
            fz = cie_f((xyz[2] * 1000000 + 544377) / 1088754);
            lv = to_frac(116 * longint'(fy) - 16 * longint'(ONE));
            av = to_frac(500 * (longint'(fx) - longint'(fy)));
            bv = to_frac(200 * (longint'(fy) - longint'(fz)));
            lmax = 100 << FRAC_BITS;
            if (lmax > 2047) lmax = 2047;
            e.lightness = 11'(sat(lv, 0, lmax));
            e.gr_axis   = 12'(sat(av, -2048, 2047));
            e.by_axis   = 12'(sat(bv, -2048, 2047));
            e.fe        = fe;
            pending.push_back(e);
            pixels++;
            if (fe) frames++;
        endfunction

        function void check_lab(lab_t got);
            lab_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result with nothing outstanding");
                return;
            end
            e = pending.pop_front();
            if (got.lightness !== e.lightness || got.gr_axis !== e.gr_axis ||
                got.by_axis !== e.by_axis || got.fe !== e.fe) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: L/a/b/fe exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                             e.lightness, e.gr_axis, e.by_axis, e.fe,
                             got.lightness, got.gr_axis, got.by_axis, got.fe);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    slab_pix_if pix();
    slab_lab_if lab();

    srgb_to_cielab_converter #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix.sink),
        .o_lab   (lab.source)
    );

    lab_scoreboard sb = new();
    bit no_idle = 0;

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    function automatic int gap_len();
        if (no_idle) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid     <= 1'b1;
        pix.red       <= r;
        pix.green     <= g;
        pix.blue      <= b;
        pix.frame_end <= fe;
        do @(posedge i_clk); while (!pix.ready);
        sb.note_pixel(r, g, b, fe);
    endtask

    // receiver back-pressure
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            lab.ready  <= 1'b0;
        end else begin
            stall_left <= gap_len();
            lab.ready  <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        lab_t got;
        if (i_rst_n && lab.valid && lab.ready) begin
            got.lightness = lab.lightness;
            got.gr_axis   = lab.green_red_axis;
            got.by_axis   = lab.blue_yellow_axis;
            got.fe        = lab.frame_end_out;
            sb.check_lab(got);
        end
    end

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [7:0] r, g, b;
        int sel;
        i_rst_n = 1'b0;
        pix.valid = 1'b0;
        pix.red = '0;
        pix.green = '0;
        pix.blue = '0;
        pix.frame_end = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // black, white, primaries, secondaries, and both sides of the gamma knee
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd10, 8'd10, 8'd10, 1'b0);
        send_pixel(8'd11, 8'd11, 8'd11, 1'b0);
        send_pixel(8'd10, 8'd11, 8'd1, 1'b0);
        send_pixel(8'd1, 8'd1, 8'd1, 1'b1);
        // grays around the epsilon crossover of f(), then mid gray, near-white, red and cyan
        send_pixel(8'd20, 8'd20, 8'd20, 1'b0);
        send_pixel(8'd23, 8'd23, 8'd23, 1'b0);
        send_pixel(8'd24, 8'd24, 8'd24, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd254, 8'd254, 8'd254, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b1);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 9);
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            if (sel == 0) begin
                g = r;
                b = r;
            end else if (sel == 1) begin
                r = 8'($urandom_range(0, 30));
                g = 8'($urandom_range(0, 30));
                b = 8'($urandom_range(0, 30));
            end
            send_pixel(r, g, b, $urandom_range(0, 15) == 0);
        end
        pix.valid <= 1'b0;
        no_idle = 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);

        $display("Converted %0d pixels over %0d frame ends, random gaps and stalls on both sides",
                 sb.pixels, sb.frames);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
